>>> src/gccc_pkg.sv
package gccc_pkg;

    localparam int ID_W            = 16;
    localparam int COORD_W         = 8;
    localparam int DELTA_W         = COORD_W + 1;
    localparam int PROD_W          = 2 * DELTA_W;
    localparam int STATUS_W        = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 8;
    localparam int MAX_CPR_DEFAULT = 255;

    localparam logic [CFG_IDX_W-1:0] REG_CORNERS_PER_ROW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_ROWS     = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_COINCIDENT = 2'd1,
        ST_RANGE      = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0] corner_id;
        logic            last;
    } t_in;

    typedef struct packed {
        logic                collinear;
        logic [STATUS_W-1:0] status;
    } t_out;

    typedef struct packed {
        logic valid;
        logic oor;
        logic last;
    } t_commit;

endpackage

>>> src/grid_corner_collinearity_check.sv
// A result enters the output register once its beat's divide is done and the beat commits.
// A new input beat is taken only after the previous beat has committed; the radix-2 divider
// retires one quotient bit per cycle over the 16-bit corner index.
// A beat that must post a result waits while the output register is full and stalled.
// Reset (i_rst_n low, synchronous) clears the run state and the output valid
// and sets both geometry registers to 1.
module grid_corner_collinearity_check #(
    parameter int MAX_CORNERS_PER_ROW = gccc_pkg::MAX_CPR_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  gccc_pkg::t_in                   i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output gccc_pkg::t_out                  o_out,
    input  logic                            i_cfg_we,
    input  logic [gccc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gccc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gccc_pkg::*;

    localparam int CPR_FULL = (2 ** COORD_W) - 1;
    localparam logic [COORD_W-1:0] CPR_CAP = (MAX_CORNERS_PER_ROW > CPR_FULL) ?
        COORD_W'(CPR_FULL) : COORD_W'(MAX_CORNERS_PER_ROW);

    t_state             r_state, n_state;
    logic [COORD_W-1:0] r_cpr;
    logic [COORD_W-1:0] r_rows;
    logic               r_last;
    logic               r_oor;
    logic               r_out_valid;
    t_out               r_out;

    logic [COORD_W-1:0] cpr_eff;
    logic [ID_W-1:0]    total;
    logic               in_take;
    logic               out_free;
    logic               div_done;
    logic [COORD_W-1:0] div_quot;
    logic [COORD_W-1:0] div_rem;
    t_commit            commit;
    t_out               res;

    always_comb begin
        cpr_eff = (r_cpr > CPR_CAP) ? CPR_CAP : r_cpr;
        total   = cpr_eff * r_rows;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (commit.valid) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        out_free     = !r_out_valid || !i_out_stall;
        o_in_stall   = (r_state != S_IDLE);
        in_take      = i_in_valid && (r_state == S_IDLE);
        commit.valid = (r_state == S_DIV) && div_done && (!r_last || out_free);
        commit.oor   = r_oor;
        commit.last  = r_last;
    end

    gccc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_take),
        .i_dividend (i_in.corner_id),
        .i_divisor  (cpr_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    gccc_geom u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_col    (div_rem),
        .i_row    (div_quot),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cpr       <= COORD_W'(1);
            r_rows      <= COORD_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CORNERS_PER_ROW: r_cpr  <= i_cfg_data;
                    REG_CORNER_ROWS:     r_rows <= i_cfg_data;
                    default: ;
                endcase
            end
            if (commit.valid && r_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_take) begin
            r_last <= i_in.last;
            r_oor  <= (cpr_eff == '0) || (i_in.corner_id >= total);
        end
        if (commit.valid && r_last) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_take_starts_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == S_DIV) && !div_done)
        else $error("accepted beat did not start a divide");

    a_slot_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && !(commit.valid && r_last)) |=> !r_out_valid)
        else $error("delivered result not dropped");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status != 2'd3) && !(o_out.collinear && o_out.status != ST_OK))
        else $error("result fields inconsistent");

endmodule

>>> src/gccc_div.sv
module gccc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gccc_pkg::ID_W-1:0]    i_dividend,
    input  logic [gccc_pkg::COORD_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [gccc_pkg::COORD_W-1:0] o_quot,
    output logic [gccc_pkg::COORD_W-1:0] o_rem
);
    import gccc_pkg::*;

    localparam int CNT_W = $clog2(ID_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ID_W - 2);

    logic [COORD_W-1:0] r_rem, n_rem;
    logic [ID_W-1:0]    r_quo, n_quo;
    logic [COORD_W-1:0] r_div, n_div;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;

    logic [COORD_W-1:0] s_rem;
    logic [ID_W-1:0]    s_quo;
    logic [COORD_W-1:0] s_div;
    logic [COORD_W:0]   trial;
    logic               ge;

    always_comb begin
        s_rem = i_start ? '0 : r_rem;
        s_quo = i_start ? i_dividend : r_quo;
        s_div = i_start ? i_divisor : r_div;
        trial = {s_rem, s_quo[ID_W-1]};
        ge    = trial >= {1'b0, s_div};
    end

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = r_done;
        if (i_start) begin
            n_div  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
        if (i_start || r_busy) begin
            n_rem = ge ? COORD_W'(trial - {1'b0, s_div}) : trial[COORD_W-1:0];
            n_quo = {s_quo[ID_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_quo[COORD_W-1:0];
    assign o_rem  = r_rem;

    a_start_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> !o_done && r_busy)
        else $error("divider done while a new divide runs");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_div != '0) |-> (r_rem < r_div))
        else $error("remainder not below divisor");

endmodule

>>> src/gccc_geom.sv
module gccc_geom (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gccc_pkg::t_commit            i_commit,
    input  logic [gccc_pkg::COORD_W-1:0] i_col,
    input  logic [gccc_pkg::COORD_W-1:0] i_row,
    output gccc_pkg::t_out               o_res
);
    import gccc_pkg::*;

    logic [1:0]                r_count, n_count;
    logic [COORD_W-1:0]        r_first_col, n_first_col;
    logic [COORD_W-1:0]        r_first_row, n_first_row;
    logic signed [DELTA_W-1:0] r_delta_col, n_delta_col;
    logic signed [DELTA_W-1:0] r_delta_row, n_delta_row;
    logic                      r_still, n_still;
    logic [STATUS_W-1:0]       r_err, n_err;

    logic signed [DELTA_W-1:0] off_col;
    logic signed [DELTA_W-1:0] off_row;
    logic signed [PROD_W-1:0]  prod_a;
    logic signed [PROD_W-1:0]  prod_b;

    always_comb begin
        off_col = $signed({1'b0, i_col}) - $signed({1'b0, r_first_col});
        off_row = $signed({1'b0, i_row}) - $signed({1'b0, r_first_row});
        prod_a  = off_col * r_delta_row;
        prod_b  = off_row * r_delta_col;
    end

    always_comb begin
        n_count     = r_count;
        n_first_col = r_first_col;
        n_first_row = r_first_row;
        n_delta_col = r_delta_col;
        n_delta_row = r_delta_row;
        n_still     = r_still;
        n_err       = r_err;
        if (i_commit.oor) begin
            n_err = ST_RANGE;
        end else begin
            case (r_count)
                2'd0: begin
                    n_first_col = i_col;
                    n_first_row = i_row;
                end
                2'd1: begin
                    n_delta_col = off_col;
                    n_delta_row = off_row;
                end
                default: begin
                    if (r_delta_col == '0 && r_delta_row == '0) begin
                        if (r_err == ST_OK) begin
                            n_err = ST_COINCIDENT;
                        end
                    end else if (prod_a != prod_b) begin
                        n_still = 1'b0;
                    end
                end
            endcase
        end
        if (r_count != 2'd2) begin
            n_count = r_count + 2'd1;
        end
        o_res.collinear = (n_err == ST_OK) && n_still;
        o_res.status    = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_first_col <= '0;
            r_first_row <= '0;
            r_delta_col <= '0;
            r_delta_row <= '0;
            r_still     <= 1'b1;
            r_err       <= ST_OK;
        end else if (i_commit.valid) begin
            if (i_commit.last) begin
                r_count     <= '0;
                r_first_col <= '0;
                r_first_row <= '0;
                r_delta_col <= '0;
                r_delta_row <= '0;
                r_still     <= 1'b1;
                r_err       <= ST_OK;
            end else begin
                r_count     <= n_count;
                r_first_col <= n_first_col;
                r_first_row <= n_first_row;
                r_delta_col <= n_delta_col;
                r_delta_row <= n_delta_row;
                r_still     <= n_still;
                r_err       <= n_err;
            end
        end
    end

endmodule
